>>> hdl/wst_pkg.sv
// shared types and constants for the weighted sum tree sampler
// no dependencies; imported by wst_cell and weighted_sum_tree_sampler
`default_nettype none

package wst_pkg;

  localparam int SUM_W  = 48;  // width of every inner sum and of the total
  localparam int IDX_W  = 10;  // entry_index and found_index field width
  localparam int RATE_W = 32;  // leaf_rate field width
  localparam int ACT_W  = 3;
  localparam int LVL_W  = 5;   // holds a tree level number up to 31

  typedef enum logic [ACT_W-1:0] {
    ACT_UPDATE  = 3'd0,
    ACT_WRITE   = 3'd1,
    ACT_REBUILD = 3'd2,
    ACT_SEARCH  = 3'd3,
    ACT_READ    = 3'd4,
    ACT_CLEAR   = 3'd5
  } wst_act_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_CLR,
    CMD_PRD,
    CMD_ADD,
    CMD_SCAN
  } wst_cmd_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_PRD1,
    ST_PRD2,
    ST_ADD,
    ST_SCAN,
    ST_SRCH,
    ST_LRD1,
    ST_LRD2,
    ST_CLR,
    ST_DONE
  } wst_state_t;

  // control broadcast from the sequencer to every level cell
  typedef struct packed {
    wst_cmd_t         cmd;
    logic             add_inner;  // update: inner levels take the delta too
    logic [LVL_W-1:0] scan_lvl;   // level being rebuilt
    logic             scan_wr;    // a child beat arrives this cycle
    logic             scan_odd;   // the beat is the right child
  } wst_ctl_t;

endpackage

`default_nettype wire

>>> hdl/wst_ram.sv
// generic simple dual port ram with registered read
// no dependencies
`default_nettype none

module wst_ram #(
  parameter int W  = 48,
  parameter int AW = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem_r [1<<AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/wst_cell.sv
// one tree level: node store plus search step and rebuild accumulator
// depends on wst_pkg and wst_ram
`default_nettype none

module wst_cell import wst_pkg::*; #(
  parameter int K   = 1,
  parameter int LVL = 1,
  parameter int W   = 48
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire wst_ctl_t         ctl_i,
  input  wire logic [LVL-1:0]   addr_i,
  input  wire logic [LVL-1:0]   addr_d_i,
  input  wire logic [LVL-1:0]   pt_i,
  input  wire logic [SUM_W-1:0] delta_i,
  input  wire logic [SUM_W-1:0] child_q_i,
  output logic      [SUM_W-1:0] q_o,
  input  wire logic             srch_vld_i,
  input  wire logic [LVL-1:0]   srch_pos_i,
  input  wire logic [SUM_W-1:0] srch_rem_i,
  output logic                  srch_vld_o,
  output logic      [LVL-1:0]   srch_pos_o,
  output logic      [SUM_W-1:0] srch_rem_o
);

  localparam int AW = K;
  localparam bit IS_LEAF = (K == LVL);

  logic            we;
  logic [AW-1:0]   waddr;
  logic [W-1:0]    wdata;
  logic [AW-1:0]   raddr;
  logic [W-1:0]    q;
  logic [AW-1:0]   pt_addr;
  logic            scan_me;
  logic            go_right;

  logic             s_vld_r;
  logic [LVL-1:0]   s_pos_r;
  logic [SUM_W-1:0] s_rem_r;
  logic             o_vld_r;
  logic [LVL-1:0]   o_pos_r;
  logic [SUM_W-1:0] o_rem_r;
  logic [SUM_W-1:0] acc_r;

  assign pt_addr = AW'(pt_i >> (LVL - K));
  assign q_o     = SUM_W'(q);
  assign scan_me = (ctl_i.cmd == CMD_SCAN) && (ctl_i.scan_lvl == LVL_W'(K)) && ctl_i.scan_wr;

  always_comb begin
    we    = 1'b0;
    waddr = pt_addr;
    wdata = W'(q_o + delta_i);
    unique case (ctl_i.cmd)
      CMD_CLR: begin
        we    = 1'b1;
        waddr = AW'(addr_i);
        wdata = '0;
      end
      CMD_ADD: begin
        we = IS_LEAF || ctl_i.add_inner;
      end
      CMD_SCAN: begin
        we    = scan_me && ctl_i.scan_odd;
        waddr = AW'(addr_d_i >> 1);
        wdata = W'(acc_r + child_q_i);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // search has the read port alone while its beat passes
  always_comb begin
    if (srch_vld_i) begin
      raddr = AW'(srch_pos_i << 1);
    end else if (ctl_i.cmd == CMD_SCAN) begin
      raddr = AW'(addr_i);
    end else begin
      raddr = pt_addr;
    end
  end

  wst_ram #(.W(W), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (q)
  );

  assign go_right = (q_o <= s_rem_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      s_vld_r <= srch_vld_i;
      o_vld_r <= s_vld_r;
    end
    s_pos_r <= srch_pos_i << 1;
    s_rem_r <= srch_rem_i;
    o_pos_r <= s_pos_r | LVL'(go_right);
    o_rem_r <= go_right ? (s_rem_r - q_o) : s_rem_r;
    if (scan_me && !ctl_i.scan_odd) begin
      acc_r <= child_q_i;
    end
  end

  assign srch_vld_o = o_vld_r;
  assign srch_pos_o = o_pos_r;
  assign srch_rem_o = o_rem_r;

endmodule

`default_nettype wire

>>> hdl/weighted_sum_tree_sampler.sv
// sum tree sampler: update, write-only, read, search, clear and rebuild actions,
// one item at a time, as in_tready is high only while idle.
// a result waits in the output register while the next beat is taken.
// after reset the block sweeps all level stores to zero, with in_tready low,
// then goes idle. depends on wst_pkg and wst_cell.
`default_nettype none

module weighted_sum_tree_sampler import wst_pkg::*; #(
  parameter int LEAVES    = 1024,
  parameter int RATE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,  // entry_index[9:0], amount[57:10], zero fill
  input  wire logic [2:0]  in_tuser,  // action[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [95:0] out_tdata  // found_index[9:0], leaf_rate[41:10],
                                      // total_rate[89:42], beyond_total[90], zero fill
);

  localparam int LVL = (LEAVES <= 2) ? 1 : $clog2(LEAVES);
  localparam int PAD = 1 << LVL;
  localparam logic [SUM_W-1:0] RATE_MAX  = SUM_W'((64'd1 << RATE_BITS) - 64'd1);
  localparam logic [LVL-1:0]   LAST_LEAF = LVL'(PAD - 1);
  localparam logic [LVL-1:0]   TOP_LEAF  = LVL'(LEAVES - 1);

  wst_state_t state_r, state_nxt;
  wst_ctl_t   ctl;

  logic [IDX_W-1:0] in_idx;
  logic [SUM_W-1:0] in_amt;
  wst_act_t         in_act;
  logic             in_idx_ok;
  logic             accept;

  logic [LVL-1:0]     addr_r, addr_nxt, addr_d_r;
  logic               vd_r, vd_nxt;
  logic               tail_r, tail_nxt;
  logic [LVL_W-1:0]   lvl_r, lvl_nxt;
  wst_act_t           act_r, act_nxt;
  logic               idx_ok_r, idx_ok_nxt;
  logic [LVL-1:0]     idx_r, idx_nxt;
  logic [SUM_W-1:0]   amt_r, amt_nxt;
  logic [RATE_BITS-1:0] v_r, v_nxt;
  logic [SUM_W-1:0]   total_r, total_nxt;
  logic [SUM_W-1:0]   delta_r, delta_nxt;
  logic [SUM_W-1:0]   acc_r, acc_nxt;
  logic               srch_go_r, srch_go_nxt;
  logic [LVL-1:0]     found_r, found_nxt;
  logic [RATE_BITS-1:0] rate_r, rate_nxt;
  logic               beyond_r, beyond_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic [95:0]        out_data_r, out_data_nxt;

  logic [LVL:0]       one_w, span_w;
  logic               scan_last;
  logic [LVL-1:0]     found_raw, found_clamp;
  logic [SUM_W-1:0]   sat_amt;

  logic [SUM_W-1:0] q_w  [1:LVL+1];
  logic             sv_w [0:LVL];
  logic [LVL-1:0]   sp_w [0:LVL];
  logic [SUM_W-1:0] sr_w [0:LVL];

  assign in_idx    = in_tdata[9:0];
  assign in_amt    = in_tdata[57:10];
  assign in_act    = wst_act_t'(in_tuser);
  assign in_idx_ok = 32'(in_idx) < 32'(LEAVES);
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign sat_amt   = (in_amt > RATE_MAX) ? RATE_MAX : in_amt;

  // last source index of the current rebuild level
  assign one_w     = (LVL+1)'(1);
  assign span_w    = (one_w << (lvl_r + LVL_W'(1))) - one_w;
  assign scan_last = (addr_r == LVL'(span_w));

  assign found_raw   = sp_w[LVL];
  assign found_clamp = (found_raw > TOP_LEAF) ? TOP_LEAF : found_raw;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (addr_r == LAST_LEAF) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_act)
            ACT_UPDATE, ACT_WRITE: state_nxt = in_idx_ok ? ST_PRD1 : ST_DONE;
            ACT_REBUILD:           state_nxt = ST_SCAN;
            ACT_SEARCH:            state_nxt = ST_SRCH;
            ACT_CLEAR:             state_nxt = ST_CLR;
            default:               state_nxt = in_idx_ok ? ST_LRD1 : ST_DONE;
          endcase
        end
      end
      ST_PRD1: state_nxt = ST_PRD2;
      ST_PRD2: state_nxt = ST_ADD;
      ST_ADD:  state_nxt = ST_DONE;
      ST_SCAN: begin
        if (tail_r && (lvl_r == '0)) state_nxt = idx_ok_r ? ST_LRD1 : ST_DONE;
      end
      ST_SRCH: begin
        if (sv_w[LVL]) state_nxt = ST_LRD1;
      end
      ST_LRD1: state_nxt = ST_LRD2;
      ST_LRD2: state_nxt = ST_DONE;
      ST_CLR: begin
        if (addr_r == LAST_LEAF) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_vld_r || out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // cell control and datapath
  always_comb begin
    ctl.cmd       = CMD_NONE;
    ctl.add_inner = (act_r == ACT_UPDATE);
    ctl.scan_lvl  = lvl_r;
    ctl.scan_wr   = vd_r;
    ctl.scan_odd  = addr_d_r[0];

    addr_nxt    = addr_r;
    vd_nxt      = 1'b0;
    tail_nxt    = tail_r;
    lvl_nxt     = lvl_r;
    act_nxt     = act_r;
    idx_ok_nxt  = idx_ok_r;
    idx_nxt     = idx_r;
    amt_nxt     = amt_r;
    v_nxt       = v_r;
    total_nxt   = total_r;
    delta_nxt   = delta_r;
    acc_nxt     = acc_r;
    srch_go_nxt = 1'b0;
    found_nxt   = found_r;
    rate_nxt    = rate_r;
    beyond_nxt  = beyond_r;
    out_vld_nxt = out_vld_r && !out_tready;
    out_data_nxt = out_data_r;

    unique case (state_r)
      ST_INIT, ST_CLR: begin
        ctl.cmd  = CMD_CLR;
        addr_nxt = addr_r + LVL'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          act_nxt    = in_act;
          idx_ok_nxt = in_idx_ok;
          idx_nxt    = LVL'(in_idx);
          amt_nxt    = in_amt;
          v_nxt      = RATE_BITS'(sat_amt);
          addr_nxt   = '0;
          tail_nxt   = 1'b0;
          lvl_nxt    = LVL_W'(LVL - 1);
          found_nxt  = '0;
          beyond_nxt = 1'b0;
          rate_nxt   = '0;
          case (in_act)
            ACT_UPDATE, ACT_WRITE: rate_nxt = in_idx_ok ? RATE_BITS'(sat_amt) : '0;
            ACT_SEARCH: begin
              beyond_nxt  = (in_amt >= total_r);
              srch_go_nxt = 1'b1;
            end
            ACT_CLEAR: total_nxt = '0;
            default: rate_nxt = '0;
          endcase
        end
      end
      ST_PRD1: ctl.cmd = CMD_PRD;
      ST_PRD2: begin
        ctl.cmd   = CMD_PRD;
        delta_nxt = SUM_W'(v_r) - q_w[LVL];
      end
      ST_ADD: begin
        ctl.cmd = CMD_ADD;
        if (act_r == ACT_UPDATE) total_nxt = total_r + delta_r;
      end
      ST_SCAN: begin
        ctl.cmd = CMD_SCAN;
        if (tail_r) begin
          tail_nxt = 1'b0;
          addr_nxt = '0;
          lvl_nxt  = lvl_r - LVL_W'(1);
        end else begin
          vd_nxt   = 1'b1;
          tail_nxt = scan_last;
          addr_nxt = addr_r + LVL'(1);
        end
        // the root sum becomes the total
        if ((lvl_r == '0) && vd_r) begin
          if (addr_d_r[0]) total_nxt = acc_r + q_w[1];
          else             acc_nxt   = q_w[1];
        end
      end
      ST_SRCH: begin
        if (sv_w[LVL]) begin
          found_nxt = found_clamp;
          idx_nxt   = found_clamp;
        end
      end
      ST_LRD1: ctl.cmd = CMD_PRD;
      ST_LRD2: rate_nxt = RATE_BITS'(q_w[LVL]);
      ST_DONE: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = {5'd0, beyond_r, total_r, RATE_W'(rate_r), IDX_W'(found_r)};
        end
      end
      default: ctl.cmd = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_INIT;
      addr_r    <= '0;
      vd_r      <= 1'b0;
      tail_r    <= 1'b0;
      srch_go_r <= 1'b0;
      out_vld_r <= 1'b0;
      total_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      addr_r    <= addr_nxt;
      vd_r      <= vd_nxt;
      tail_r    <= tail_nxt;
      srch_go_r <= srch_go_nxt;
      out_vld_r <= out_vld_nxt;
      total_r   <= total_nxt;
    end
    addr_d_r   <= addr_r;
    lvl_r      <= lvl_nxt;
    act_r      <= act_nxt;
    idx_ok_r   <= idx_ok_nxt;
    idx_r      <= idx_nxt;
    amt_r      <= amt_nxt;
    v_r        <= v_nxt;
    delta_r    <= delta_nxt;
    acc_r      <= acc_nxt;
    found_r    <= found_nxt;
    rate_r     <= rate_nxt;
    beyond_r   <= beyond_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // search beat enters at level one from the root
  assign sv_w[0]       = srch_go_r;
  assign sp_w[0]       = '0;
  assign sr_w[0]       = amt_r;
  assign q_w[LVL+1]    = '0;

  for (genvar k = 1; k <= LVL; k++) begin : g_cell
    localparam int CW = (k == LVL) ? RATE_BITS : SUM_W;
    wst_cell #(.K(k), .LVL(LVL), .W(CW)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl_i      (ctl),
      .addr_i     (addr_r),
      .addr_d_i   (addr_d_r),
      .pt_i       (idx_r),
      .delta_i    (delta_r),
      .child_q_i  (q_w[k+1]),
      .q_o        (q_w[k]),
      .srch_vld_i (sv_w[k-1]),
      .srch_pos_i (sp_w[k-1]),
      .srch_rem_i (sr_w[k-1]),
      .srch_vld_o (sv_w[k]),
      .srch_pos_o (sp_w[k]),
      .srch_rem_o (sr_w[k])
    );
  end

endmodule

`default_nettype wire

>>> tb/tb_weighted_sum_tree_sampler.sv
// self-checking bench for weighted_sum_tree_sampler: random and directed beats,
// with a behavioral sum tree predicting every result; depends on wst_pkg and the rtl
`default_nettype none

module tb_weighted_sum_tree_sampler;
  import wst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NLEAF = 1024;
  localparam logic [SUM_W-1:0] RATE_TOP = (48'd1 << 32) - 48'd1;

  typedef struct packed {
    logic [2:0]  act;
    logic [9:0]  idx;
    logic [47:0] amt;
  } op_t;

  typedef struct packed {
    logic [9:0]  found;
    logic [31:0] rate;
    logic [47:0] total;
    logic        beyond;
  } res_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [63:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [95:0] out_tdata;

  weighted_sum_tree_sampler dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #10 clk = ~clk;

  // behavioral tree: node 1 root, leaves at NLEAF..2*NLEAF-1
  logic [SUM_W-1:0] tree [1:2*NLEAF-1];
  logic [SUM_W-1:0] grand_total;
  op_t  pending_ops[$];
  res_t expected_res[$];
  int   n_err = 0;
  bit   stim_done = 0;

  function automatic logic [31:0] leaf_rate_of(logic [10:0] i);
    return (i < NLEAF) ? tree[NLEAF + i][31:0] : 32'd0;
  endfunction

  function automatic res_t apply_op(op_t o);
    res_t r;
    logic [SUM_W-1:0] v, delta, rem;
    int n;
    r = '0;
    case (o.act)
      ACT_UPDATE, ACT_WRITE: begin
        v = (o.amt > RATE_TOP) ? RATE_TOP : o.amt;
        if (o.act == ACT_UPDATE) begin
          delta = v - tree[NLEAF + o.idx];
          grand_total = grand_total + delta;
          for (n = (NLEAF + o.idx) >> 1; n >= 1; n = n >> 1) tree[n] = tree[n] + delta;
        end
        tree[NLEAF + o.idx] = v;
        r.rate = leaf_rate_of(o.idx);
      end
      ACT_REBUILD: begin
        for (n = NLEAF - 1; n >= 1; n--) tree[n] = tree[2*n] + tree[2*n+1];
        grand_total = tree[1];
        r.rate = leaf_rate_of(o.idx);
      end
      ACT_SEARCH: begin
        rem = o.amt;
        r.beyond = (o.amt >= grand_total);
        n = 1;
        while (n < NLEAF) begin
          if (tree[2*n] <= rem) begin
            rem = rem - tree[2*n];
            n = 2*n + 1;
          end else begin
            n = 2*n;
          end
        end
        r.found = 10'(n - NLEAF);
        r.rate = leaf_rate_of(11'(n - NLEAF));
      end
      ACT_CLEAR: begin
        for (n = 1; n < 2*NLEAF; n++) tree[n] = '0;
        grand_total = '0;
      end
      default: r.rate = leaf_rate_of(o.idx);
    endcase
    r.total = grand_total;
    return r;
  endfunction

  function automatic op_t mk(logic [2:0] a, logic [9:0] i, logic [47:0] m);
    op_t o;
    o.act = a; o.idx = i; o.amt = m;
    return o;
  endfunction

  function automatic logic [47:0] rand_amt();
    case ($urandom_range(0, 5))
      0: return 48'({$urandom, $urandom});
      1: return 48'($urandom_range(0, 1000));
      2: return RATE_TOP - 48'($urandom_range(0, 3));
      default: return 48'($urandom & 32'h00FF_FFFF);
    endcase
  endfunction

  // beat taken at the last rising edge
  logic in_tready_seen = 0;
  always @(posedge clk) in_tready_seen <= in_tvalid && in_tready;

  // driver: bursts of beats with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready_seen) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 0;
        end else if (pending_ops.size() > 0) begin
          op_t o;
          o = pending_ops.pop_front();
          expected_res.push_back(apply_op(o));
          in_tuser <= o.act;
          in_tdata <= {6'd0, o.amt, o.idx};
          in_tvalid <= 1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 0;
        end
      end
    end
  end

  // receiver stall pattern: alternating windows of free flow and random stalls
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase % 400 < 150) out_tready <= 1;
    else out_tready <= ($urandom_range(0, 2) != 0);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      res_t got, want;
      got.found = out_tdata[9:0];
      got.rate = out_tdata[41:10];
      got.total = out_tdata[89:42];
      got.beyond = out_tdata[90];
      if (expected_res.size() == 0) begin
        $error("result beat with nothing expected");
        n_err++;
      end else begin
        want = expected_res.pop_front();
        if (got.found !== want.found) begin
          $error("found_index exp %0d got %0d", want.found, got.found); n_err++;
        end
        if (got.rate !== want.rate) begin
          $error("leaf_rate exp %0d got %0d", want.rate, got.rate); n_err++;
        end
        if (got.total !== want.total) begin
          $error("total_rate exp %0d got %0d", want.total, got.total); n_err++;
        end
        if (got.beyond !== want.beyond) begin
          $error("beyond_total exp %0d got %0d", want.beyond, got.beyond); n_err++;
        end
      end
    end
  end

  initial begin
    int k, r;
    for (k = 1; k < 2*NLEAF; k++) tree[k] = '0;
    grand_total = '0;
    // directed: extremes, every action, saturation, stale sums, padding-free ends
    pending_ops.push_back(mk(ACT_SEARCH, 0, 0));
    pending_ops.push_back(mk(ACT_UPDATE, 0, 48'hFFFF_FFFF_FFFF));
    pending_ops.push_back(mk(ACT_UPDATE, 1023, 5));
    pending_ops.push_back(mk(ACT_UPDATE, 512, RATE_TOP));
    pending_ops.push_back(mk(ACT_READ, 1023, 0));
    pending_ops.push_back(mk(ACT_SEARCH, 10, RATE_TOP));
    pending_ops.push_back(mk(ACT_SEARCH, 0, 48'hFFFF_FFFF_FFFF));
    pending_ops.push_back(mk(ACT_WRITE, 7, 1000));
    pending_ops.push_back(mk(ACT_SEARCH, 0, 48'd1));
    pending_ops.push_back(mk(ACT_SEARCH, 0, 48'd3*RATE_TOP));
    pending_ops.push_back(mk(ACT_REBUILD, 7, 0));
    pending_ops.push_back(mk(ACT_SEARCH, 0, 48'd2*RATE_TOP + 1002));
    pending_ops.push_back(mk(3'd6, 7, 0));
    pending_ops.push_back(mk(3'd7, 1023, 48'hFFFF_FFFF_FFFF));
    pending_ops.push_back(mk(ACT_WRITE, 1022, 48'h8000_0000_0000));
    pending_ops.push_back(mk(ACT_UPDATE, 1022, 0));
    pending_ops.push_back(mk(ACT_CLEAR, 3, 0));
    pending_ops.push_back(mk(ACT_READ, 512, 0));
    pending_ops.push_back(mk(ACT_SEARCH, 0, 0));
    // random: mostly updates and searches into a loaded tree, occasional rebuilds
    for (k = 0; k < 800; k++) begin
      op_t o;
      r = $urandom_range(0, 99);
      o.idx = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                          : 10'($urandom_range(0, 15));
      o.amt = rand_amt();
      if (r < 35) o.act = ACT_UPDATE;
      else if (r < 45) o.act = ACT_WRITE;
      else if (r < 50) o.act = ACT_REBUILD;
      else if (r < 85) begin
        o.act = ACT_SEARCH;
        if ($urandom_range(0, 3) != 0 && grand_total != 0)
          o.amt = 48'({$urandom, $urandom} % grand_total);
      end else if (r < 94) o.act = ACT_READ;
      else if (r < 96) o.act = ACT_CLEAR;
      else o.act = 3'($urandom_range(6, 7));
      pending_ops.push_back(o);
    end
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1;
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    wait (pending_ops.size() == 0 && expected_res.size() == 0 && !in_tvalid);
    repeat (50) @(posedge clk);
    if (n_err == 0 && expected_res.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // slowest item is a rebuild; 820 of those plus stalls is about 35 ms
  initial begin
    #200ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
